FILE: sv/bfa_pkg.sv
package bfa_pkg;

  localparam int ADDR_BITS = 16;

  typedef struct packed {
    logic        req_type;
    logic [15:0] alloc_size;
    logic [9:0]  request_index;
  } in_word_t;

  typedef struct packed {
    logic [15:0] start_address;
    logic [1:0]  status;
  } out_word_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_GRD,
    S_SCAN,
    S_UPD1,
    S_UPD2,
    S_FIN
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic grd;
    logic scan;
    logic upd1;
    logic upd2;
    logic push;
    logic clr_start;
    logic clr_run;
  } ctl_cmd_t;

  typedef struct packed {
    logic reduce_done;
    logic scan_done;
    logic clr_done;
    logic out_busy;
  } ctl_sts_t;

endpackage

FILE: sv/bfa_ctrl.sv
module bfa_ctrl import bfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     cfg_valid,
  input  ctl_sts_t sts,
  output logic     in_ready,
  output logic     cfg_ready,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cfg_ready = 1'b1;
        cmd.clr_run = 1'b1;
        if (cfg_valid) begin
          cmd.clr_start = 1'b1;
        end else if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready = !cfg_valid;
        if (cfg_valid) begin
          cmd.clr_start = 1'b1;
          state_nxt = S_CLEAR;
        end else if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        if (sts.reduce_done) begin
          state_nxt = S_GRD;
        end
      end
      S_GRD: begin
        cmd.grd = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_UPD1;
        end
      end
      S_UPD1: begin
        cmd.upd1 = 1'b1;
        state_nxt = S_UPD2;
      end
      S_UPD2: begin
        cmd.upd2 = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.push = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

FILE: sv/bfa_dp.sv
module bfa_dp import bfa_pkg::*; #(
  parameter int MAX_FREE_SEGMENTS = 64,
  parameter int MAX_REQUESTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_word_t    in_word,
  input  logic        cfg_fire,
  input  logic [15:0] cfg_data,
  input  logic        out_ready,
  input  ctl_cmd_t    cmd,
  output ctl_sts_t    sts,
  output logic        out_valid,
  output out_word_t   out_word
);

  localparam int A = ADDR_BITS;
  localparam int N = MAX_FREE_SEGMENTS;
  localparam int FW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int RB = $clog2(MAX_REQUESTS);
  localparam int RQW = (RB > 10) ? RB : 10;
  localparam int XW = (A > 16) ? A : 16;
  localparam int GW = 2 * A + 1;

  logic [2*A-1:0] fmem [N];
  logic [GW-1:0]  gmem [MAX_REQUESTS];

  logic [15:0]    msize_r;
  logic [N-1:0]   used_r;
  logic [RB-1:0]  num_r;
  logic [RB-1:0]  clr_r;
  logic           type_r;
  logic [A-1:0]   size_r;
  logic [RQW-1:0] idx_r;

  logic [CW-1:0]  scan_i_r;
  logic           pv_r;
  logic [FW-1:0]  pidx_r;
  logic [2*A-1:0] frd_r;
  logic [GW-1:0]  grd_r;

  logic           found_r;
  logic [FW-1:0]  best_idx_r;
  logic [A:0]     best_len_r;
  logic [A-1:0]   best_first_r, best_last_r;
  logic           lf_r, rf_r, ef_r;
  logic [FW-1:0]  left_idx_r, right_idx_r, empty_idx_r;
  logic [A-1:0]   left_first_r, right_last_r;

  out_word_t      res_r;
  logic           out_valid_r;
  out_word_t      out_word_r;

  logic [XW-1:0]  size_x, msize_x, start_x;
  logic [A-1:0]   msize_a;
  logic [RB-1:0]  idx;
  logic           issue;
  logic [A-1:0]   f, l, lo, hi;
  logic           u, g_live, live_ok, fit, better;
  logic [A:0]     len;
  logic           alloc_ok, rel_ok;

  logic           fwe;
  logic [FW-1:0]  fwa;
  logic [2*A-1:0] fwd;
  logic           gwe;
  logic [RB-1:0]  gwa;
  logic [GW-1:0]  gwd;
  out_word_t      res;

  assign size_x  = XW'(in_word.alloc_size);
  assign msize_x = XW'(msize_r);
  assign msize_a = msize_x[A-1:0];
  assign idx     = idx_r[RB-1:0];
  assign issue   = cmd.scan && (scan_i_r < CW'(N));

  assign f      = frd_r[2*A-1:A];
  assign l      = frd_r[A-1:0];
  assign u      = used_r[pidx_r];
  assign g_live = grd_r[GW-1];
  assign lo     = grd_r[2*A-1:A];
  assign hi     = grd_r[A-1:0];
  assign live_ok = g_live && (idx != num_r);
  assign len    = {1'b0, l} - {1'b0, f} + (A+1)'(1);
  assign fit    = u && (size_r != '0) && (len >= {1'b0, size_r});
  assign better = !found_r || (len < best_len_r) ||
                  ((len == best_len_r) && (f < best_first_r));

  assign alloc_ok = (type_r != REQ_RELEASE) && found_r;
  assign rel_ok   = (type_r == REQ_RELEASE) && live_ok && (lf_r || rf_r || ef_r);

  assign sts.reduce_done = (32'(idx_r) < 32'(MAX_REQUESTS));
  assign sts.scan_done   = pv_r && (pidx_r == FW'(N - 1));
  assign sts.clr_done    = (clr_r == RB'(MAX_REQUESTS - 1));
  assign sts.out_busy    = out_valid_r && !out_ready;

  assign start_x = XW'(best_first_r);

  always_comb begin
    fwe = 1'b0;
    fwa = '0;
    fwd = {A'(1), msize_a};
    gwe = 1'b0;
    gwa = clr_r;
    gwd = '0;
    res.start_address = '0;
    res.status = ST_OK;
    if (cmd.clr_run) begin
      fwe = 1'b1;
      gwe = 1'b1;
    end else if (cmd.upd1) begin
      gwe = 1'b1;
      gwa = num_r;
      if (type_r != REQ_RELEASE) begin
        if (alloc_ok) begin
          res.start_address = start_x[15:0];
          gwd = {1'b1, best_first_r, best_first_r + size_r - A'(1)};
          if (best_len_r != {1'b0, size_r}) begin
            fwe = 1'b1;
            fwa = best_idx_r;
            fwd = {best_first_r + size_r, best_last_r};
          end
        end else begin
          res.status = ST_NOFIT;
        end
      end else if (!live_ok) begin
        res.status = ST_IGNORED;
      end else begin
        priority if (lf_r && rf_r) begin
          fwe = 1'b1;
          fwa = left_idx_r;
          fwd = {left_first_r, right_last_r};
        end else if (lf_r) begin
          fwe = 1'b1;
          fwa = left_idx_r;
          fwd = {left_first_r, hi};
        end else if (rf_r) begin
          fwe = 1'b1;
          fwa = right_idx_r;
          fwd = {lo, right_last_r};
        end else if (ef_r) begin
          fwe = 1'b1;
          fwa = empty_idx_r;
          fwd = {lo, hi};
        end else begin
          res.status = ST_FULL;
        end
      end
    end else if (cmd.upd2 && rel_ok) begin
      gwe = 1'b1;
      gwa = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      fmem[fwa] <= fwd;
    end
    if (issue) begin
      frd_r <= fmem[scan_i_r[FW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (gwe) begin
      gmem[gwa] <= gwd;
    end
    if (cmd.grd) begin
      grd_r <= gmem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msize_r <= 16'hFFFF;
      used_r <= N'(1);
      num_r <= RB'(1);
      clr_r <= '0;
      pv_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        msize_r <= cfg_data;
        used_r <= N'(cfg_data != 16'd0);
        num_r <= RB'(1);
      end else if (cmd.push) begin
        num_r <= (num_r == RB'(MAX_REQUESTS - 1)) ? '0 : num_r + RB'(1);
      end
      if (cmd.upd1) begin
        if (alloc_ok && (best_len_r == {1'b0, size_r})) begin
          used_r[best_idx_r] <= 1'b0;
        end
        if ((type_r == REQ_RELEASE) && live_ok) begin
          if (lf_r && rf_r) begin
            used_r[right_idx_r] <= 1'b0;
          end else if (!lf_r && !rf_r && ef_r) begin
            used_r[empty_idx_r] <= 1'b1;
          end
        end
      end
      if (cmd.clr_start) begin
        clr_r <= '0;
      end else if (cmd.clr_run && !sts.clr_done) begin
        clr_r <= clr_r + RB'(1);
      end
      pv_r <= issue;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= in_word.req_type;
      size_r <= size_x[A-1:0];
      idx_r <= RQW'(in_word.request_index);
      scan_i_r <= '0;
      found_r <= 1'b0;
      lf_r <= 1'b0;
      rf_r <= 1'b0;
      ef_r <= 1'b0;
    end
    if (cmd.reduce && !sts.reduce_done) begin
      idx_r <= idx_r - RQW'(MAX_REQUESTS);
    end
    if (issue) begin
      scan_i_r <= scan_i_r + CW'(1);
      pidx_r <= scan_i_r[FW-1:0];
    end
    if (pv_r) begin
      if (fit && better) begin
        found_r <= 1'b1;
        best_idx_r <= pidx_r;
        best_len_r <= len;
        best_first_r <= f;
        best_last_r <= l;
      end
      if (!u) begin
        if (!ef_r) begin
          ef_r <= 1'b1;
          empty_idx_r <= pidx_r;
        end
      end else begin
        if ({1'b0, f} == {1'b0, hi} + (A+1)'(1)) begin
          rf_r <= 1'b1;
          right_idx_r <= pidx_r;
          right_last_r <= l;
        end
        if ({1'b0, l} + (A+1)'(1) == {1'b0, lo}) begin
          lf_r <= 1'b1;
          left_idx_r <= pidx_r;
          left_first_r <= f;
        end
      end
    end
    if (cmd.upd1) begin
      res_r <= res;
    end
    if (cmd.push) begin
      out_word_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: sv/best_fit_allocator_coalescing.sv
// Best-fit allocator over the units 1..memory_size with coalescing on release.
// The in_ channel takes one request word (allocate or release) under valid and
// ready; the out_ channel returns one result word per request, start address
// and status, under valid and ready. The cfg_ channel writes memory_size and
// restarts the pool as one free segment with all grants cleared.
// Each request walks the free segment table once through its single read
// port, one entry per cycle. A request index of MAX_REQUESTS or more is
// first reduced by repeated subtraction of MAX_REQUESTS. One request is in
// flight at a time.
// After reset and after every configuration write the grant memory is swept
// clear, one entry per cycle, and no request is taken until the sweep ends;
// configuration writes are still taken during it.
// The result goes to an output register, so the next request is accepted
// while a result waits; a stalled receiver holds a finished request only
// when that register is still occupied.
module best_fit_allocator_coalescing import bfa_pkg::*; #(
  parameter int MAX_FREE_SEGMENTS = 64,
  parameter int MAX_REQUESTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .in_ready  (in_ready),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  bfa_dp #(
    .MAX_FREE_SEGMENTS (MAX_FREE_SEGMENTS),
    .MAX_REQUESTS      (MAX_REQUESTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

FILE: test/tb_best_fit_allocator_coalescing.sv
`timescale 1ns / 100ps

module tb_best_fit_allocator_coalescing;
  import bfa_pkg::*;

  localparam int NSEG = 64;
  localparam int NREQ = 1024;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_word;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  best_fit_allocator_coalescing u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Allocator state mirrored for prediction.
  logic [15:0] pool_size;
  logic [15:0] seg_lo [NSEG];
  logic [15:0] seg_hi [NSEG];
  logic        seg_on [NSEG];
  logic [15:0] blk_lo [NREQ];
  logic [15:0] blk_hi [NREQ];
  logic        blk_on [NREQ];
  logic [9:0]  req_num;
  logic [9:0]  frag_base;

  out_word_t expected_words[$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off = 0;
  int hold_reqs = 0;
  int hold_seen = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void restart_pool(input logic [15:0] size);
    pool_size = size;
    for (int i = 0; i < NSEG; i++) begin
      seg_on[i] = 1'b0;
    end
    for (int i = 0; i < NREQ; i++) begin
      blk_on[i] = 1'b0;
    end
    if (size != 0) begin
      seg_lo[0] = 16'd1;
      seg_hi[0] = size;
      seg_on[0] = 1'b1;
    end
    req_num = 10'd1;
  endfunction

  function automatic out_word_t allocate_or_release(input in_word_t w);
    out_word_t r;
    int best;
    int right;
    int left;
    int empty;
    logic [16:0] len;
    logic [16:0] best_len;
    logic [15:0] lo;
    logic [15:0] hi;
    r.start_address = '0;
    r.status = ST_OK;
    best = -1;
    right = -1;
    left = -1;
    empty = -1;
    best_len = '0;
    blk_on[req_num] = 1'b0;
    if (w.req_type != REQ_RELEASE) begin
      if (w.alloc_size == 0) begin
        r.status = ST_NOFIT;
      end else begin
        for (int i = 0; i < NSEG; i++) begin
          if (seg_on[i]) begin
            len = {1'b0, seg_hi[i]} - {1'b0, seg_lo[i]} + 17'd1;
            if (len >= {1'b0, w.alloc_size} && (best < 0 || len < best_len ||
                (len == best_len && seg_lo[i] < seg_lo[best]))) begin
              best = i;
              best_len = len;
            end
          end
        end
        if (best < 0) begin
          r.status = ST_NOFIT;
        end else begin
          r.start_address = seg_lo[best];
          blk_lo[req_num] = seg_lo[best];
          blk_hi[req_num] = seg_lo[best] + w.alloc_size - 16'd1;
          blk_on[req_num] = 1'b1;
          if (best_len == {1'b0, w.alloc_size}) begin
            seg_on[best] = 1'b0;
          end else begin
            seg_lo[best] = seg_lo[best] + w.alloc_size;
          end
        end
      end
    end else if (!blk_on[w.request_index]) begin
      r.status = ST_IGNORED;
    end else begin
      lo = blk_lo[w.request_index];
      hi = blk_hi[w.request_index];
      for (int i = 0; i < NSEG; i++) begin
        if (!seg_on[i]) begin
          if (empty < 0) begin
            empty = i;
          end
        end else begin
          if ({1'b0, seg_lo[i]} == {1'b0, hi} + 17'd1) begin
            right = i;
          end
          if ({1'b0, seg_hi[i]} + 17'd1 == {1'b0, lo}) begin
            left = i;
          end
        end
      end
      if (left >= 0 && right >= 0) begin
        seg_hi[left] = seg_hi[right];
        seg_on[right] = 1'b0;
      end else if (left >= 0) begin
        seg_hi[left] = hi;
      end else if (right >= 0) begin
        seg_lo[right] = lo;
      end else if (empty < 0) begin
        r.status = ST_FULL;
      end else begin
        seg_lo[empty] = lo;
        seg_hi[empty] = hi;
        seg_on[empty] = 1'b1;
      end
      if (r.status == ST_OK) begin
        blk_on[w.request_index] = 1'b0;
      end
    end
    req_num = req_num + 10'd1;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb_best_fit_allocator_coalescing failed");
    $finish;
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    expected_words.insert(expected_words.size(), allocate_or_release(w));
  endtask

  task automatic send_and_check(input in_word_t w, input bit fixed,
                                input logic [15:0] addr, input logic [1:0] st);
    out_word_t r;
    send_word(w);
    if (fixed) begin
      r = expected_words[$];
      if (r.start_address != addr || r.status != st) begin
        report_mismatch($sformatf("directed row gives %h/%0d, table says %h/%0d",
                                  r.start_address, r.status, addr, st));
      end
    end
  endtask

  task automatic drain;
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (expected_words.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (150) @(posedge clk);
  endtask

  task automatic write_size(input logic [15:0] size);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    restart_pool(size);
  endtask

  function automatic in_word_t make_alloc(input logic [15:0] size);
    in_word_t w;
    w.req_type = ~REQ_RELEASE;
    w.alloc_size = size;
    w.request_index = 10'($urandom);
    return w;
  endfunction

  function automatic in_word_t make_release(input logic [9:0] idx);
    in_word_t w;
    w.req_type = REQ_RELEASE;
    w.alloc_size = 16'($urandom);
    w.request_index = idx;
    return w;
  endfunction

  // One random word: mostly small allocations and releases of recent grants.
  function automatic in_word_t random_word(input logic [15:0] size);
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      return make_alloc(16'($urandom_range(1, (size < 64) ? 64 : size / 16)));
    end else if (pick < 50) begin
      return make_alloc(16'($urandom));
    end else if (pick < 90) begin
      return make_release(req_num - 10'($urandom_range(1, 40)));
    end else begin
      return make_release(10'($urandom));
    end
  endfunction

  // Fragments the pool so releases run out of free table entries.
  task automatic fragment_pool;
    frag_base = req_num;
    for (int i = 0; i < 140; i++) begin
      send_word(make_alloc(16'd1));
    end
    for (int i = 0; i < 140; i += 2) begin
      send_word(make_release(frag_base + 10'(i)));
    end
  endtask

  typedef struct {
    in_word_t w;
    bit fixed;
    logic [15:0] addr;
    logic [1:0] st;
  } stim_row_t;

  stim_row_t stim_rows[$];

  task automatic add_row(input in_word_t w, input bit fixed,
                         input logic [15:0] addr, input logic [1:0] st);
    stim_row_t r;
    r.w = w;
    r.fixed = fixed;
    r.addr = addr;
    r.st = st;
    stim_rows.insert(stim_rows.size(), r);
  endtask

  initial begin
    logic [15:0] sizes[5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    send_idle_pct = 23;
    recv_idle_pct = 55;
    restart_pool(16'hFFFF);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    add_row(make_alloc(16'd0), 1, 16'd0, ST_NOFIT);
    add_row(make_alloc(16'd10), 1, 16'd1, ST_OK);
    add_row(make_alloc(16'd5), 1, 16'd11, ST_OK);
    add_row(make_alloc(16'hFFFF), 1, 16'd0, ST_NOFIT);
    add_row(make_release(10'd2), 1, 16'd0, ST_OK);
    add_row(make_release(10'd2), 1, 16'd0, ST_IGNORED);
    add_row(make_release(10'd4), 1, 16'd0, ST_IGNORED);
    add_row(make_release(10'd8), 1, 16'd0, ST_IGNORED);
    add_row(make_release(10'h3FF), 1, 16'd0, ST_IGNORED);
    add_row(make_alloc(16'd3), 0, 16'd0, ST_OK);
    add_row(make_alloc(16'd7), 0, 16'd0, ST_OK);
    add_row(make_release(10'd3), 0, 16'd0, ST_OK);
    add_row(make_release(10'd10), 0, 16'd0, ST_OK);
    add_row(make_release(10'd11), 0, 16'd0, ST_OK);
    add_row(make_alloc(16'hFFFE), 0, 16'd0, ST_OK);
    add_row(make_alloc(16'd1), 0, 16'd0, ST_OK);
    add_row(make_alloc(16'd1), 0, 16'd0, ST_OK);
    foreach (stim_rows[i]) begin
      send_and_check(stim_rows[i].w, stim_rows[i].fixed, stim_rows[i].addr,
                     stim_rows[i].st);
    end

    write_size(16'd0);
    send_and_check(make_alloc(16'd1), 1, 16'd0, ST_NOFIT);
    write_size(16'd1);
    send_and_check(make_alloc(16'd1), 1, 16'd1, ST_OK);
    send_and_check(make_alloc(16'd1), 1, 16'd0, ST_NOFIT);
    send_and_check(make_release(10'd1), 1, 16'd0, ST_OK);

    write_size(16'd300);
    fragment_pool();
    hold_reqs++;
    for (int i = 0; i < 10; i++) begin
      send_word(make_release(frag_base + 10'd1 + 10'(2 * i)));
    end
    drain();

    sizes = '{16'd200, 16'd1000, 16'd64, 16'hFFFF, 16'd5000};
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        send_idle_pct = 55;
        recv_idle_pct = 23;
      end else if (p == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < 2; k++) begin
        write_size(sizes[(2 * p + k) % 5]);
        for (int i = 0; i < 60; i++) begin
          send_word(random_word(pool_size));
        end
        drain();
      end
    end

    drain();
    if (expected_words.size() != 0) begin
      report_mismatch($sformatf("%0d results never came", expected_words.size()));
    end
    if (errors == 0) begin
      $display("tb_best_fit_allocator_coalescing passed");
    end else begin
      $display("tb_best_fit_allocator_coalescing failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_off <= 400;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        e = expected_words.pop_front();
        if (out_word.start_address != e.start_address) begin
          report_mismatch($sformatf("start_address %h, expected %h",
                                    out_word.start_address, e.start_address));
        end
        if (out_word.status != e.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_word.status, e.status));
        end
      end
    end
  end

endmodule
